[sv/mme_pkg.sv]
// shared types and constants for the matrix multiply engine
// no dependencies

package mme_pkg;

  localparam int MaxDim    = 64;
  localparam int DimW      = $clog2(MaxDim);
  localparam int ElemW     = 32;
  localparam int FracW     = 16;
  localparam int CfgW      = 7;
  localparam int CfgIdxW   = 2;
  localparam int AddrW     = 2 * DimW;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int ProdW     = 2 * ElemW;
  localparam int AccW      = ProdW + DimW;
  localparam int CmdDepth  = 4;
  localparam int CmdPtrW   = $clog2(CmdDepth);
  localparam int ResDepth  = 2;
  localparam int ResPtrW   = $clog2(ResDepth);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRowsInUse  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerInUse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgColsInUse  = 2'd2;

  localparam logic [CfgW-1:0] CfgResetDim = CfgW'(MaxDim);

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_UNUSED  = 2'd3
  } mme_op_e;

  typedef enum logic [1:0] {
    KIND_WRITE_A = 2'd0,
    KIND_WRITE_B = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_ZERO    = 2'd3
  } mme_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } mme_back_state_e;

  typedef struct packed {
    logic [1:0]             op;
    logic [DimW-1:0]        row_index;
    logic [DimW-1:0]        col_index;
    logic signed [ElemW-1:0] element_value;
  } mme_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] product_sum;
    logic                    saturated;
  } mme_out_t;

  typedef struct packed {
    mme_kind_e       kind;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
    logic [ElemW-1:0] value;
    logic [CfgW-1:0] inner;
  } mme_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mme_q_status_t;

endpackage

[sv/mme_front.sv]
// front end: configuration registers and request classification
// depends on mme_pkg

module mme_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mme_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mme_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         push_i,
  input  mme_pkg::mme_in_t             item_i,
  input  mme_pkg::mme_q_status_t       q_status_i,
  output logic                         q_push_o,
  output mme_pkg::mme_cmd_t            q_cmd_o
);

  logic [mme_pkg::CfgW-1:0] rows_q, inner_q, cols_q;
  logic [mme_pkg::CfgW-1:0] inner_clamped;
  logic                     out_of_range;
  logic                     accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mme_pkg::CfgResetDim;
      inner_q <= mme_pkg::CfgResetDim;
      cols_q  <= mme_pkg::CfgResetDim;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mme_pkg::CfgRowsInUse:  rows_q  <= cfg_data_i;
        mme_pkg::CfgInnerInUse: inner_q <= cfg_data_i;
        mme_pkg::CfgColsInUse:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign inner_clamped = (inner_q > mme_pkg::CfgResetDim) ? mme_pkg::CfgResetDim : inner_q;
  assign out_of_range  = ({1'b0, item_i.row_index} >= rows_q) ||
                         ({1'b0, item_i.col_index} >= cols_q) ||
                         (inner_q == '0);
  assign accept        = push_i && !q_status_i.full;

  always_comb begin
    q_push_o      = 1'b0;
    q_cmd_o.kind  = mme_pkg::KIND_ZERO;
    q_cmd_o.row   = item_i.row_index;
    q_cmd_o.col   = item_i.col_index;
    q_cmd_o.value = item_i.element_value;
    q_cmd_o.inner = inner_clamped;
    unique case (mme_pkg::mme_op_e'(item_i.op))
      mme_pkg::OP_WRITE_A: begin
        q_push_o     = accept;
        q_cmd_o.kind = mme_pkg::KIND_WRITE_A;
      end
      mme_pkg::OP_WRITE_B: begin
        q_push_o     = accept;
        q_cmd_o.kind = mme_pkg::KIND_WRITE_B;
      end
      mme_pkg::OP_COMPUTE: begin
        q_push_o     = accept;
        q_cmd_o.kind = out_of_range ? mme_pkg::KIND_ZERO : mme_pkg::KIND_COMPUTE;
      end
      default: q_push_o = 1'b0;
    endcase
  end

endmodule

[sv/mme_cmd_queue.sv]
// short request queue between the front end and the back end
// depends on mme_pkg

module mme_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mme_pkg::mme_cmd_t      cmd_i,
  input  logic                   pop_i,
  output mme_pkg::mme_cmd_t      cmd_o,
  output mme_pkg::mme_q_status_t status_o
);

  mme_pkg::mme_cmd_t              entries_q [mme_pkg::CmdDepth];
  logic [mme_pkg::CmdPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [mme_pkg::CmdPtrW:0]      count_q;
  logic                           do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == (mme_pkg::CmdPtrW+1)'(mme_pkg::CmdDepth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign cmd_o          = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= cmd_i;
  end

endmodule

[sv/mme_back.sv]
// back end: element stores, multiply-accumulate loop and result queue
// depends on mme_pkg

module mme_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mme_pkg::mme_cmd_t      cmd_i,
  input  mme_pkg::mme_q_status_t cmd_status_i,
  output logic                   cmd_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output mme_pkg::mme_out_t      result_o
);

  localparam int AccW  = mme_pkg::AccW;
  localparam int ElemW = mme_pkg::ElemW;

  logic [ElemW-1:0] mem_a [mme_pkg::StoreDepth];
  logic [ElemW-1:0] mem_b [mme_pkg::StoreDepth];

  mme_pkg::mme_back_state_e state_q, state_d;

  logic [mme_pkg::DimW-1:0]  row_q, col_q;
  logic [mme_pkg::CfgW-1:0]  inner_q, k_q;
  logic                      rd_v_q, mul_v_q;
  logic signed [ElemW-1:0]   a_rd_q, b_rd_q;
  logic signed [mme_pkg::ProdW-1:0] mul_q;
  logic signed [AccW-1:0]    acc_q, shifted;

  logic wr_a, wr_b, issue, start, out_push, out_zero;
  logic [mme_pkg::AddrW-1:0] wr_addr, a_addr, b_addr;
  logic sat_hi, sat_lo;
  mme_pkg::mme_out_t computed, out_data;

  mme_pkg::mme_out_t           res_q [mme_pkg::ResDepth];
  logic [mme_pkg::ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [mme_pkg::ResPtrW:0]   res_cnt_q;
  logic                        out_full, res_pop;

  assign wr_addr = {cmd_i.row, cmd_i.col};
  assign a_addr  = {row_q, k_q[mme_pkg::DimW-1:0]};
  assign b_addr  = {k_q[mme_pkg::DimW-1:0], col_q};

  // element stores, registered reads
  always_ff @(posedge clk_i) begin
    if (wr_a)  mem_a[wr_addr] <= cmd_i.value;
    if (issue) a_rd_q <= mem_a[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b)  mem_b[wr_addr] <= cmd_i.value;
    if (issue) b_rd_q <= mem_b[b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mme_pkg::BK_IDLE;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (start)      k_q <= '0;
      else if (issue) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q   <= cmd_i.row;
      col_q   <= cmd_i.col;
      inner_q <= cmd_i.inner;
    end
    if (rd_v_q) mul_q <= a_rd_q * b_rd_q;
    if (start)        acc_q <= '0;
    else if (mul_v_q) acc_q <= acc_q + {{(AccW-mme_pkg::ProdW){mul_q[mme_pkg::ProdW-1]}}, mul_q};
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    out_push  = 1'b0;
    out_zero  = 1'b0;
    unique case (state_q)
      mme_pkg::BK_IDLE: begin
        if (!cmd_status_i.empty) begin
          unique case (cmd_i.kind)
            mme_pkg::KIND_WRITE_A: begin
              wr_a      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            mme_pkg::KIND_WRITE_B: begin
              wr_b      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            mme_pkg::KIND_COMPUTE: begin
              if (!out_full) begin
                start     = 1'b1;
                cmd_pop_o = 1'b1;
                state_d   = mme_pkg::BK_RUN;
              end
            end
            default: begin
              if (!out_full) begin
                out_push  = 1'b1;
                out_zero  = 1'b1;
                cmd_pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      mme_pkg::BK_RUN: begin
        issue = 1'b1;
        if (k_q == inner_q - 1'b1) state_d = mme_pkg::BK_DRAIN;
      end
      mme_pkg::BK_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          out_push = 1'b1;
          state_d  = mme_pkg::BK_IDLE;
        end
      end
      default: state_d = mme_pkg::BK_IDLE;
    endcase
  end

  // floor to q16.16 and saturate
  assign shifted = acc_q >>> mme_pkg::FracW;
  assign sat_hi  = !shifted[AccW-1] && (|shifted[AccW-2:ElemW-1]);
  assign sat_lo  = shifted[AccW-1] && !(&shifted[AccW-2:ElemW-1]);

  always_comb begin
    computed.saturated = sat_hi || sat_lo;
    if (sat_hi)      computed.product_sum = {1'b0, {(ElemW-1){1'b1}}};
    else if (sat_lo) computed.product_sum = {1'b1, {(ElemW-1){1'b0}}};
    else             computed.product_sum = shifted[ElemW-1:0];
  end

  assign out_data = out_zero ? '0 : computed;

  // result queue
  assign empty_o  = (res_cnt_q == '0);
  assign out_full = (res_cnt_q == (mme_pkg::ResPtrW+1)'(mme_pkg::ResDepth));
  assign res_pop  = pop_i && !empty_o;
  assign result_o = res_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (out_push) res_wr_q <= res_wr_q + 1'b1;
      if (res_pop)  res_rd_q <= res_rd_q + 1'b1;
      unique case ({out_push, res_pop})
        2'b10:   res_cnt_q <= res_cnt_q + 1'b1;
        2'b01:   res_cnt_q <= res_cnt_q - 1'b1;
        default: res_cnt_q <= res_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) res_q[res_wr_q] <= out_data;
  end

endmodule

[sv/matrix_multiply_engine_unit.sv]
// a request for C[row][col] runs through the multiply-accumulate loop, with registered
// store reads, product and accumulator, and then enters the result queue; element writes
// retire one a cycle while the back end is idle; one request at a time holds the loop
// asynchronous active-low reset empties both queues and sets all sizes to 64
// element stores are not cleared by reset
// top level of the matrix multiply engine, depends on mme_pkg and the mme_* modules

module matrix_multiply_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mme_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mme_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  mme_pkg::mme_in_t             item_i,
  output logic                         empty,
  input  logic                         pop,
  output mme_pkg::mme_out_t            result_o
);

  logic                   q_push, q_pop;
  mme_pkg::mme_cmd_t      q_in, q_out;
  mme_pkg::mme_q_status_t q_status;

  mme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .item_i     (item_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in)
  );

  mme_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (q_in),
    .pop_i    (q_pop),
    .cmd_o    (q_out),
    .status_o (q_status)
  );

  mme_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_out),
    .cmd_status_i (q_status),
    .cmd_pop_o    (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result_o)
  );

  assign full = q_status.full;

endmodule

[sv/mme_checker.sv]
// port-level checks for the matrix multiply engine, bound to the top level
// depends on mme_pkg and matrix_multiply_engine_unit

module mme_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input mme_pkg::mme_out_t result_o
);

  // reset leaves the result queue empty and the request queue not full
  assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed");

  // a saturated result sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.saturated |->
      result_o.product_sum == 32'sh7fffffff || result_o.product_sum == 32'sh80000000)
    else $error("saturated flag without clamped value");

  // a zero result, such as an out-of-range or empty sum, never flags saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.product_sum == '0 |-> !result_o.saturated)
    else $error("zero result flagged as saturated");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .result_o (result_o)
);

[sim/tb_matrix_multiply_engine_unit.sv]
// testbench for matrix_multiply_engine_unit: element writes and C requests go in through
// the push/full side, results are checked against an in-bench matrix predictor
// depends on mme_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_matrix_multiply_engine_unit;

  localparam int ClkPeriod    = 20;
  localparam int CycleLimit   = 3_000_000;
  localparam int SettleCycles = 80;
  localparam int HoldCycles   = 400;
  localparam int SumW         = 80;
  localparam logic signed [SumW-1:0] SumMax = 80'sh7FFF_FFFF;
  localparam logic signed [SumW-1:0] SumMin = -80'sh8000_0000;

  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        cfg_we_i   = 1'b0;
  logic [mme_pkg::CfgIdxW-1:0] cfg_idx_i  = mme_pkg::CfgRowsInUse;
  logic [mme_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        push       = 1'b0;
  logic                        full;
  mme_pkg::mme_in_t            item_i     = '0;
  logic                        empty;
  logic                        pop        = 1'b0;
  mme_pkg::mme_out_t           result_o;

  logic signed [mme_pkg::ElemW-1:0] left_elems  [mme_pkg::StoreDepth];
  logic signed [mme_pkg::ElemW-1:0] right_elems [mme_pkg::StoreDepth];
  bit left_known  [mme_pkg::StoreDepth];
  bit right_known [mme_pkg::StoreDepth];

  logic [mme_pkg::CfgW-1:0] size_rows  = mme_pkg::CfgResetDim;
  logic [mme_pkg::CfgW-1:0] size_inner = mme_pkg::CfgResetDim;
  logic [mme_pkg::CfgW-1:0] size_cols  = mme_pkg::CfgResetDim;

  mme_pkg::mme_in_t  req_backlog [$];
  mme_pkg::mme_out_t sums_due [$];
  mme_pkg::mme_out_t due_sum;

  int items_queued = 0;
  int items_taken  = 0;
  int c_requests   = 0;
  int results_seen = 0;
  int fail_count   = 0;
  int send_gap     = 0;
  int recv_stall   = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  bit send_quiet   = 1'b0;
  bit recv_quiet   = 1'b0;
  bit wide_values  = 1'b0;
  logic hold_start = 1'b0;

  matrix_multiply_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [mme_pkg::ElemW-1:0] pick_elem(bit wide);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < (wide ? 4 : 9)) return $urandom_range(0, 32'h1F_FFFF) - 32'h0010_0000;
    if (wide && sel < 7) return $urandom();
    case ($urandom_range(0, wide ? 6 : 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0001_0000;
      4:       return 32'hFFFF_0000;
      5:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // stores writes and works out C[row][col] for each accepted request
  function automatic void mirror_request(mme_pkg::mme_in_t it);
    logic signed [SumW-1:0] acc;
    longint prod;
    int depth;
    mme_pkg::mme_out_t res;
    case (mme_pkg::mme_op_e'(it.op))
      mme_pkg::OP_WRITE_A: left_elems[{it.row_index, it.col_index}] = it.element_value;
      mme_pkg::OP_WRITE_B: right_elems[{it.row_index, it.col_index}] = it.element_value;
      mme_pkg::OP_COMPUTE: begin
        res = '0;
        if (it.row_index < size_rows && it.col_index < size_cols) begin
          depth = (size_inner > mme_pkg::MaxDim) ? mme_pkg::MaxDim : int'(size_inner);
          acc = '0;
          for (int k = 0; k < depth; k++) begin
            prod = longint'(left_elems[int'(it.row_index) * mme_pkg::MaxDim + k])
                 * longint'(right_elems[k * mme_pkg::MaxDim + int'(it.col_index)]);
            acc = acc + SumW'(prod);
          end
          acc = acc >>> mme_pkg::FracW;
          if (acc > SumMax) begin
            res.product_sum = SumMax[mme_pkg::ElemW-1:0];
            res.saturated   = 1'b1;
          end else if (acc < SumMin) begin
            res.product_sum = SumMin[mme_pkg::ElemW-1:0];
            res.saturated   = 1'b1;
          end else begin
            res.product_sum = acc[mme_pkg::ElemW-1:0];
          end
        end
        sums_due.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(mme_pkg::mme_op_e op, int row, int col,
                                     logic [mme_pkg::ElemW-1:0] value);
    mme_pkg::mme_in_t it;
    it.op            = op;
    it.row_index     = row[mme_pkg::DimW-1:0];
    it.col_index     = col[mme_pkg::DimW-1:0];
    it.element_value = value;
    if (op == mme_pkg::OP_WRITE_A) left_known[row * mme_pkg::MaxDim + col] = 1'b1;
    if (op == mme_pkg::OP_WRITE_B) right_known[row * mme_pkg::MaxDim + col] = 1'b1;
    req_backlog.push_back(it);
    items_queued++;
  endfunction

  // writes any element the request reads that has no value yet, then the request
  function automatic void queue_c_request(int row, int col);
    int depth;
    depth = (size_inner > mme_pkg::MaxDim) ? mme_pkg::MaxDim : int'(size_inner);
    if (row < size_rows && col < size_cols) begin
      for (int k = 0; k < depth; k++) begin
        if (!left_known[row * mme_pkg::MaxDim + k])
          queue_item(mme_pkg::OP_WRITE_A, row, k, pick_elem(wide_values));
        if (!right_known[k * mme_pkg::MaxDim + col])
          queue_item(mme_pkg::OP_WRITE_B, k, col, pick_elem(wide_values));
      end
    end
    queue_item(mme_pkg::OP_COMPUTE, row, col, $urandom());
  endfunction

  task automatic write_size(logic [mme_pkg::CfgIdxW-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[mme_pkg::CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mme_pkg::CfgRowsInUse:  size_rows  = value[mme_pkg::CfgW-1:0];
      mme_pkg::CfgInnerInUse: size_inner = value[mme_pkg::CfgW-1:0];
      mme_pkg::CfgColsInUse:  size_cols  = value[mme_pkg::CfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(int rows, int inner, int cols);
    write_size(mme_pkg::CfgRowsInUse, rows);
    write_size(mme_pkg::CfgInnerInUse, inner);
    write_size(mme_pkg::CfgColsInUse, cols);
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued) @(posedge clk_i);
    while (results_seen != c_requests) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int rows, int inner, int cols, int count, int window, bit wide,
                           bit quiet_send, bit quiet_recv, bit long_hold);
    int lim_r, lim_c, win_r, win_c, depth, sel, r, c;
    set_sizes(rows, inner, cols);
    if (long_hold) begin
      hold_start <= 1'b1;
      @(posedge clk_i);
      hold_start <= 1'b0;
    end
    @(negedge clk_i);
    send_quiet  = quiet_send;
    recv_quiet  = quiet_recv;
    wide_values = wide;
    foreach (left_known[i]) begin
      left_known[i]  = 1'b0;
      right_known[i] = 1'b0;
    end
    lim_r = (rows > mme_pkg::MaxDim) ? mme_pkg::MaxDim : rows;
    lim_c = (cols > mme_pkg::MaxDim) ? mme_pkg::MaxDim : cols;
    depth = (inner > mme_pkg::MaxDim) ? mme_pkg::MaxDim : inner;
    win_r = (window < lim_r) ? window : lim_r;
    win_c = (window < lim_c) ? window : lim_c;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      r   = $urandom_range(0, mme_pkg::MaxDim - 1);
      c   = $urandom_range(0, mme_pkg::MaxDim - 1);
      if (sel < 11) begin
        if (sel < 8 && lim_r > 0 && lim_c > 0) begin
          r = ($urandom_range(0, 3) == 0) ? lim_r - 1 : $urandom_range(0, win_r - 1);
          c = ($urandom_range(0, 3) == 0) ? lim_c - 1 : $urandom_range(0, win_c - 1);
        end else if (depth > 16 && r < lim_r && c < lim_c) begin
          r = r % win_r;
          c = c % win_c;
        end
        queue_c_request(r, c);
      end else if (sel < 18) begin
        queue_item(sel[0] ? mme_pkg::OP_WRITE_B : mme_pkg::OP_WRITE_A, r, c,
                   pick_elem(wide));
      end else begin
        queue_item(mme_pkg::OP_UNUSED, r, c, $urandom());
      end
    end
    wait_drained();
  endtask

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      item_i   <= '0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        mirror_request(item_i);
        items_taken <= items_taken + 1;
        if (item_i.op == mme_pkg::OP_COMPUTE) c_requests <= c_requests + 1;
      end
      if (!(push && full)) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          push     <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          item_i   <= req_backlog.pop_front();
          push     <= 1'b1;
          send_gap <= (send_quiet || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (sums_due.size() == 0) begin
          $error("product_sum: expected none, actual %0d", result_o.product_sum);
          fail_count++;
        end else begin
          due_sum = sums_due.pop_front();
          if (result_o.product_sum !== due_sum.product_sum) begin
            $error("product_sum: expected %0d, actual %0d",
                   due_sum.product_sum, result_o.product_sum);
            fail_count++;
          end
          if (result_o.saturated !== due_sum.saturated) begin
            $error("saturated: expected %0b, actual %0b",
                   due_sum.saturated, result_o.saturated);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        pop        <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 3) == 0) recv_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_sizes(mme_pkg::MaxDim, 2, mme_pkg::MaxDim);
    @(negedge clk_i);
    queue_item(mme_pkg::OP_WRITE_A, 63, 0, 32'h7FFF_FFFF);
    queue_item(mme_pkg::OP_WRITE_A, 63, 1, 32'h7FFF_FFFF);
    queue_item(mme_pkg::OP_WRITE_B, 0, 63, 32'h7FFF_FFFF);
    queue_item(mme_pkg::OP_WRITE_B, 1, 63, 32'h7FFF_FFFF);
    queue_c_request(63, 63);
    queue_item(mme_pkg::OP_WRITE_B, 0, 0, 32'h8000_0000);
    queue_item(mme_pkg::OP_WRITE_B, 1, 0, 32'h8000_0000);
    queue_c_request(63, 0);
    queue_item(mme_pkg::OP_WRITE_A, 0, 0, 32'hFFFF_FFFF);
    queue_item(mme_pkg::OP_WRITE_A, 0, 1, 32'h0000_0000);
    queue_c_request(0, 0);
    queue_c_request(0, 63);
    queue_item(mme_pkg::OP_UNUSED, 63, 63, 32'hFFFF_FFFF);
    wait_drained();

    // empty sum, requests outside the sizes, write outside the sizes
    set_sizes(1, 0, 1);
    @(negedge clk_i);
    queue_c_request(0, 0);
    queue_c_request(63, 0);
    queue_c_request(0, 63);
    queue_item(mme_pkg::OP_WRITE_B, 3, 3, 32'h0001_0000);
    wait_drained();

    set_sizes(0, 127, 0);
    @(negedge clk_i);
    queue_c_request(0, 0);
    wait_drained();

    run_phase(8, 4, 8, 60, 64, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(64, 1, 64, 50, 64, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(3, 12, 5, 30, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(1, 127, 1, 20, 1, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(16, 8, 16, 50, 4, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(16, 16, 16, 50, 2, 1'b0, 1'b1, 1'b0, 1'b1);
    run_phase(1, 2, 1, 30, 64, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(32, 32, 0, 30, 4, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(0, 5, 7, 30, 4, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(20, 0, 20, 30, 20, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(10, 6, 64, 50, 4, 1'b1, 1'b0, 1'b1, 1'b0);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mme_pkg.sv
sv/mme_front.sv
sv/mme_cmd_queue.sv
sv/mme_back.sv
sv/matrix_multiply_engine_unit.sv
sv/mme_checker.sv
sim/tb_matrix_multiply_engine_unit.sv
